// ===== src/aal_pkg.sv =====
// ----------------------------------------------------------------------------
// Attempt limiter package
// Types, register indexes and widths shared by the attempt limiter core.
// ----------------------------------------------------------------------------
package aal_pkg;

  // Default number of users in the per-user table.
  localparam int NumUsers = 16;

  // Field widths.
  localparam int UserW  = 4;
  localparam int TimeW  = 32;
  localparam int DelayW = 16;
  localparam int CountW = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  // Reset values of the configuration registers.
  localparam logic [DelayW-1:0] DelayPerFailureRst = 16'd1000;
  localparam logic [TimeW-1:0]  DelayMaxRst        = 32'd60000;
  localparam logic [CountW-1:0] MaxAttemptsRst     = 8'd5;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DELAY_PER_FAILURE = 2'd0,
    CFG_DELAY_MAX         = 2'd1,
    CFG_MAX_ATTEMPTS      = 2'd2,
    CFG_UNUSED            = 2'd3
  } cfg_idx_e;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_OPEN   = 2'd0,
    REQ_CHANGE = 2'd1,
    REQ_CLOSE  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_THROTTLED = 2'd1,
    ST_LOCKED    = 2'd2,
    ST_AUTH_FAIL = 2'd3
  } status_e;

  // Input beat.
  typedef struct packed {
    req_e             req_type;
    logic [UserW-1:0] user_index;
    logic             hash_match;
    logic [TimeW-1:0] now_time;
  } req_t;

  // Result beat.
  typedef struct packed {
    status_e status;
    logic    open_lock;
    logic    close_lock;
    logic    store_new_hash;
  } rsp_t;

endpackage

// ===== src/auth_attempt_limiter_core.sv =====
// ----------------------------------------------------------------------------
// Attempt limiter core
// Global throttle and per-user failure counting for a passphrase lock.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_* valid/ready channel, one beat per request, and
//   each produces exactly one result beat on the out_* channel. A beat is
//   first captured in an input register; once the output register is free,
//   the throttle check, the per-user table read-modify-write and the state
//   update happen at once and the result is loaded into the output register.
//   One request per cycle is sustained while the receiver does not stall.
//   When the receiver stalls, the result waits in the output register and
//   one more request waits in the input register; then in_ready_o drops.
//   Reset clears the global counter, the timestamp, the user table and the
//   valid flags of both pipeline registers, and loads the default
//   configuration. Configuration is written through cfg_we_i / cfg_idx_i
//   / cfg_data_i while idle; the user is bound to this, and the block
//   itself does not enforce it.
// ----------------------------------------------------------------------------
module auth_attempt_limiter_core #(
  parameter int NUM_USERS = aal_pkg::NumUsers
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [aal_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [aal_pkg::CfgDataW-1:0]  cfg_data_i,
  // Request channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  aal_pkg::req_t                 in_data_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output aal_pkg::rsp_t                 out_data_o
);

  localparam int IdxW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam logic [aal_pkg::CountW-1:0] CountMax = {aal_pkg::CountW{1'b1}};

  // Configuration registers.
  logic [aal_pkg::DelayW-1:0] delay_per_failure_q;
  logic [aal_pkg::TimeW-1:0]  delay_max_q;
  logic [aal_pkg::CountW-1:0] max_attempts_q;

  // Block state.
  logic [aal_pkg::CountW-1:0] global_attempts_q, global_attempts_d;
  logic [aal_pkg::TimeW-1:0]  last_stamp_q, last_stamp_d;
  logic [aal_pkg::CountW-1:0] fail_count_q [NUM_USERS];
  logic                       locked_q     [NUM_USERS];

  // Pipeline registers.
  logic          req_valid_q;
  aal_pkg::req_t req_q;
  logic          out_valid_q;
  aal_pkg::rsp_t rsp_q;
  aal_pkg::rsp_t rsp_d;

  // Per-user table write.
  logic                       tbl_we;
  logic [aal_pkg::CountW-1:0] tbl_count;
  logic                       tbl_lock;

  logic        advance;
  logic [31:0] user_ext;
  logic        user_in_range;
  logic [IdxW-1:0] user_idx;
  logic [aal_pkg::DelayW+aal_pkg::CountW-1:0] delay_raw;
  logic [aal_pkg::TimeW-1:0] delay;
  logic [aal_pkg::TimeW-1:0] elapsed;
  logic        throttled;
  logic [aal_pkg::CountW-1:0] cnt_inc;
  logic [aal_pkg::CountW-1:0] ga_inc;

  // Handshake: the held request moves on when the output register is free.
  assign advance     = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !req_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_per_failure_q <= aal_pkg::DelayPerFailureRst;
      delay_max_q         <= aal_pkg::DelayMaxRst;
      max_attempts_q      <= aal_pkg::MaxAttemptsRst;
    end else if (cfg_we_i) begin
      unique case (aal_pkg::cfg_idx_e'(cfg_idx_i))
        aal_pkg::CFG_DELAY_PER_FAILURE: begin
          delay_per_failure_q <= cfg_data_i[aal_pkg::DelayW-1:0];
        end
        aal_pkg::CFG_DELAY_MAX: begin
          delay_max_q <= cfg_data_i[aal_pkg::TimeW-1:0];
        end
        aal_pkg::CFG_MAX_ATTEMPTS: begin
          max_attempts_q <= cfg_data_i[aal_pkg::CountW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_data_i;
    end
  end

  // User lookup.
  assign user_ext      = 32'(req_q.user_index);
  assign user_in_range = user_ext < 32'(NUM_USERS);
  assign user_idx      = user_ext[IdxW-1:0];

  // Throttle: delay grows with the attempt count, capped at the maximum.
  assign delay_raw = delay_per_failure_q * global_attempts_q;
  assign delay     = (32'(delay_raw) > delay_max_q) ? delay_max_q : 32'(delay_raw);
  assign elapsed   = req_q.now_time - last_stamp_q;
  assign throttled = (global_attempts_q != '0) && (elapsed < delay);

  assign ga_inc  = (global_attempts_q == CountMax) ? global_attempts_q
                                                   : global_attempts_q + 1'b1;
  assign cnt_inc = (fail_count_q[user_idx] == CountMax) ? fail_count_q[user_idx]
                                                        : fail_count_q[user_idx] + 1'b1;

  // Request evaluation and next state.
  always_comb begin
    rsp_d             = '0;
    rsp_d.status      = aal_pkg::ST_OK;
    global_attempts_d = global_attempts_q;
    last_stamp_d      = last_stamp_q;
    tbl_we            = 1'b0;
    tbl_count         = cnt_inc;
    tbl_lock          = 1'b0;
    unique case (req_q.req_type)
      aal_pkg::REQ_CLOSE: begin
        rsp_d.close_lock = 1'b1;
      end
      aal_pkg::REQ_OPEN, aal_pkg::REQ_CHANGE: begin
        if (throttled) begin
          rsp_d.status = aal_pkg::ST_THROTTLED;
        end else begin
          global_attempts_d = ga_inc;
          last_stamp_d      = req_q.now_time;
          priority if (!user_in_range) begin
            rsp_d.status = aal_pkg::ST_AUTH_FAIL;
          end else if (locked_q[user_idx]) begin
            rsp_d.status = aal_pkg::ST_LOCKED;
          end else if (req_q.hash_match) begin
            // A match clears both the user's and the global failure count.
            global_attempts_d = '0;
            tbl_we            = 1'b1;
            tbl_count         = '0;
            if (req_q.req_type == aal_pkg::REQ_OPEN) begin
              rsp_d.open_lock = 1'b1;
            end else begin
              rsp_d.store_new_hash = 1'b1;
            end
          end else begin
            tbl_we = 1'b1;
            if (cnt_inc >= max_attempts_q) begin
              tbl_lock     = 1'b1;
              rsp_d.status = aal_pkg::ST_LOCKED;
            end else begin
              rsp_d.status = aal_pkg::ST_AUTH_FAIL;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Global state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      global_attempts_q <= '0;
      last_stamp_q      <= '0;
    end else if (advance) begin
      global_attempts_q <= global_attempts_d;
      last_stamp_q      <= last_stamp_d;
    end
  end

  // Per-user table: at most one entry written per request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_USERS; i++) begin
        fail_count_q[i] <= '0;
        locked_q[i]     <= 1'b0;
      end
    end else if (advance && tbl_we) begin
      fail_count_q[user_idx] <= tbl_count;
      if (tbl_lock) begin
        locked_q[user_idx] <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

endmodule
